FILE: hdl/bsds_pkg.sv
// ----------------------------------------------------------------------------
// bsds_pkg
// shared types, constants and helpers for the battery soc display smoother
// ----------------------------------------------------------------------------
package bsds_pkg;

    localparam int LVL_W  = 23;                  // percent q7.16
    localparam int LW     = 46;                  // signed working width for level sums
    localparam int QW     = 43;                  // quotient magnitude bits kept
    localparam int NUM_W  = 64;                  // divider dividend width
    localparam int DEN_W  = 49;                  // divider divisor width

    localparam logic [LVL_W-1:0] FULL_LVL = 23'd6553600;
    localparam logic [LVL_W-1:0] HALF_PCT = 23'd32768;
    localparam logic [LVL_W-1:0] PCT1     = 23'd65536;
    localparam logic [LVL_W-1:0] PCT3     = 23'd196608;
    localparam logic [LVL_W-1:0] PCT5     = 23'd327680;
    localparam logic [LVL_W-1:0] PCT6     = 23'd393216;
    localparam logic [LVL_W-1:0] PCT8     = 23'd524288;
    localparam logic [LVL_W-1:0] PCT10    = 23'd655360;
    localparam logic [LVL_W-1:0] PCT90    = 23'd5898240;
    localparam logic [LVL_W-1:0] PCT92    = 23'd6029312;
    localparam logic [LVL_W-1:0] PCT95    = 23'd6225920;
    localparam logic [LVL_W-1:0] PCT97    = 23'd6356992;

    localparam logic [1:0] BST_IDLE = 2'd0;
    localparam logic [1:0] BST_CHG  = 2'd1;
    localparam logic [1:0] BST_DIS  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_TMUL, S_TDIV, S_TWAIT, S_TUPD, S_SEL, S_RM0, S_RM1,
        S_RM2, S_RM3, S_SDIV, S_SWAIT, S_SUPD, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_TMUL, OP_DIVGO, OP_TUPD, OP_SEL, OP_RM0, OP_RM1,
        OP_RM2, OP_RM3, OP_SUPD, OP_PUB
    } t_op;

    // how the shown level moves this tick
    typedef enum logic [2:0] {
        BR_HOLD, BR_END, BR_BLEND, BR_RATIO, BR_SNAP, BR_STEP, BR_KEEP
    } t_br;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic need_tdiv;
        t_br  br;
        logic ratio_ok;
    } t_stat;

    function automatic logic [LVL_W-1:0] clamp_lvl(input logic signed [LW-1:0] v);
        logic [LVL_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({{(LW-LVL_W){1'b0}}, FULL_LVL})) begin
            r = FULL_LVL;
        end else begin
            r = v[LVL_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/battery_soc_display_smoother_unit.sv
// ----------------------------------------------------------------------------
// battery_soc_display_smoother_unit
// debounced charge status, target and displayed state of charge per tick
// ----------------------------------------------------------------------------
// order of work: load the beat, target product, target division when needed,
//   target update, branch choice, ratio products on the ratio branch, shown
//   division when needed, shown update, publish; on the shared one-bit-per-cycle divider
// throughput: one tick at a time; publishing waits out any output stall, and
//   the next beat is taken once the result sits in the output register
// reset: synchronous active low, clears status run counters, both levels, the
//   nominal capacity register and the output valid flag
module battery_soc_display_smoother_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_nominal_capacity,
    // input beat
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [23:0]   i_current_ma,
    input  logic [16:0]          i_coulomb_fraction,
    input  logic signed [31:0]   i_delta_charge,
    input  logic [25:0]          i_usable_capacity,
    // result beat
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [22:0]          o_shown_percent,
    output logic [22:0]          o_target_percent,
    output logic [1:0]           o_battery_status
);
    bsds_pkg::t_cmd  cmd;
    bsds_pkg::t_stat stat;

    // the user must send register writes only while idle; the block does not enforce it, and the port never stalls
    assign o_cfg_ready = 1'b1;

    bsds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath holds the levels, the shared divider and the output register
    bsds_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_valid),
        .i_cfg_nominal_capacity (i_cfg_nominal_capacity),
        .i_current_ma           (i_current_ma),
        .i_coulomb_fraction     (i_coulomb_fraction),
        .i_delta_charge         (i_delta_charge),
        .i_usable_capacity      (i_usable_capacity),
        .i_cmd                  (cmd),
        .o_stat                 (stat),
        .o_shown_percent        (o_shown_percent),
        .o_target_percent       (o_target_percent),
        .o_battery_status       (o_battery_status)
    );
endmodule

FILE: hdl/bsds_div.sv
// ----------------------------------------------------------------------------
// bsds_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bsds_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bsds_pkg::NUM_W-1:0]    i_dividend,
    input  logic [bsds_pkg::DEN_W-1:0]    i_divisor,
    output logic                          o_busy,
    output logic [bsds_pkg::NUM_W-1:0]    o_quot
);
    localparam int NW = bsds_pkg::NUM_W;
    localparam int DW = bsds_pkg::DEN_W;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [NW-1:0] r_q;
    logic [DW:0]   trial;
    logic          ge;

    assign trial = {r_rem, r_q[NW-1]};
    assign ge    = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_d   <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? DW'(trial - {1'b0, r_d}) : trial[DW-1:0];
            r_q   <= {r_q[NW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

FILE: hdl/bsds_ctrl.sv
// ----------------------------------------------------------------------------
// bsds_ctrl
// sequencer for one tick: target step, branch choice, shown step, publish
// ----------------------------------------------------------------------------
module bsds_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  bsds_pkg::t_stat    i_stat,
    output bsds_pkg::t_cmd     o_cmd
);
    bsds_pkg::t_state r_state, n_state;
    logic             r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsds_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = bsds_pkg::OP_NONE;
        o_in_ready = 1'b0;
        n_ov       = (r_ov && i_out_ready) ? 1'b0 : r_ov;
        unique case (r_state)
            bsds_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = bsds_pkg::OP_LOAD;
                    n_state  = bsds_pkg::S_TMUL;
                end
            end
            bsds_pkg::S_TMUL: begin
                o_cmd.op = bsds_pkg::OP_TMUL;
                n_state  = bsds_pkg::S_TDIV;
            end
            bsds_pkg::S_TDIV: begin
                if (i_stat.need_tdiv) begin
                    o_cmd.op = bsds_pkg::OP_DIVGO;
                    n_state  = bsds_pkg::S_TWAIT;
                end else begin
                    n_state = bsds_pkg::S_TUPD;
                end
            end
            bsds_pkg::S_TWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = bsds_pkg::S_TUPD;
                end
            end
            bsds_pkg::S_TUPD: begin
                o_cmd.op = bsds_pkg::OP_TUPD;
                n_state  = bsds_pkg::S_SEL;
            end
            bsds_pkg::S_SEL: begin
                o_cmd.op = bsds_pkg::OP_SEL;
                case (i_stat.br) inside
                    bsds_pkg::BR_RATIO: begin
                        n_state = i_stat.ratio_ok ? bsds_pkg::S_RM0 : bsds_pkg::S_SUPD;
                    end
                    bsds_pkg::BR_END, bsds_pkg::BR_BLEND, bsds_pkg::BR_STEP: begin
                        n_state = bsds_pkg::S_SDIV;
                    end
                    default: begin
                        n_state = bsds_pkg::S_SUPD;
                    end
                endcase
            end
            bsds_pkg::S_RM0: begin
                o_cmd.op = bsds_pkg::OP_RM0;
                n_state  = bsds_pkg::S_RM1;
            end
            bsds_pkg::S_RM1: begin
                o_cmd.op = bsds_pkg::OP_RM1;
                n_state  = bsds_pkg::S_RM2;
            end
            bsds_pkg::S_RM2: begin
                o_cmd.op = bsds_pkg::OP_RM2;
                n_state  = bsds_pkg::S_RM3;
            end
            bsds_pkg::S_RM3: begin
                o_cmd.op = bsds_pkg::OP_RM3;
                n_state  = bsds_pkg::S_SDIV;
            end
            bsds_pkg::S_SDIV: begin
                o_cmd.op = bsds_pkg::OP_DIVGO;
                n_state  = bsds_pkg::S_SWAIT;
            end
            bsds_pkg::S_SWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = bsds_pkg::S_SUPD;
                end
            end
            bsds_pkg::S_SUPD: begin
                o_cmd.op = bsds_pkg::OP_SUPD;
                n_state  = bsds_pkg::S_DONE;
            end
            bsds_pkg::S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.op = bsds_pkg::OP_PUB;
                    n_ov     = 1'b1;
                    n_state  = bsds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsds_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ov;
endmodule

FILE: hdl/bsds_dp.sv
// ----------------------------------------------------------------------------
// bsds_dp
// datapath: debounce, target and shown level arithmetic, shared divider
// ----------------------------------------------------------------------------
module bsds_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [15:0]                        i_cfg_nominal_capacity,
    input  logic signed [23:0]                 i_current_ma,
    input  logic [16:0]                        i_coulomb_fraction,
    input  logic signed [31:0]                 i_delta_charge,
    input  logic [25:0]                        i_usable_capacity,
    input  bsds_pkg::t_cmd                     i_cmd,
    output bsds_pkg::t_stat                    o_stat,
    output logic [bsds_pkg::LVL_W-1:0]         o_shown_percent,
    output logic [bsds_pkg::LVL_W-1:0]         o_target_percent,
    output logic [1:0]                         o_battery_status
);
    localparam int LV = bsds_pkg::LVL_W;
    localparam int LW = bsds_pkg::LW;
    localparam int QW = bsds_pkg::QW;
    localparam int NW = bsds_pkg::NUM_W;
    localparam int DW = bsds_pkg::DEN_W;

    logic [15:0]        r_nom;
    logic signed [23:0] r_cur;
    logic [16:0]        r_frac;
    logic signed [31:0] r_dq;
    logic [25:0]        r_cap;
    logic [2:0]         r_cr, r_dr;
    logic [1:0]         r_st;
    logic [LV-1:0]      r_t, r_s;
    logic [38:0]        r_pmag;
    logic [NW-1:0]      r_nmag;
    logic [DW-1:0]      r_den;
    logic               r_neg;
    bsds_pkg::t_br      r_br;
    logic [LV-1:0]      r_rnum, r_rden;
    logic [LV-1:0]      r_o_s, r_o_t;
    logic [1:0]         r_o_st;

    // debounce of the incoming current
    logic [2:0] n_cr, n_dr;
    logic [1:0] n_st;
    logic [2:0] cr_inc, dr_inc;
    assign cr_inc = r_cr + 3'd1;
    assign dr_inc = r_dr + 3'd1;

    always_comb begin
        n_cr = '0;
        n_dr = '0;
        n_st = bsds_pkg::BST_IDLE;
        if (i_current_ma > 0) begin
            n_cr = (cr_inc >= 3'd3) ? 3'd4 : cr_inc;
            n_st = (cr_inc >= 3'd3) ? bsds_pkg::BST_CHG : bsds_pkg::BST_IDLE;
        end else if (i_current_ma < 0) begin
            n_dr = (dr_inc >= 3'd3) ? 3'd4 : dr_inc;
            n_st = (dr_inc >= 3'd3) ? bsds_pkg::BST_DIS : bsds_pkg::BST_IDLE;
        end
    end

    // divider
    logic          div_busy;
    logic [NW-1:0] div_q;
    logic          div_go;
    assign div_go = (i_cmd.op == bsds_pkg::OP_DIVGO);

    bsds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (r_nmag + NW'(r_den >> 1)),
        .i_divisor  (r_den),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    logic signed [LW-1:0] qs;
    logic signed [LW-1:0] qmag;
    assign qmag = $signed({{(LW-QW){1'b0}}, div_q[QW-1:0]});
    assign qs   = r_neg ? -qmag : qmag;

    // common views
    logic [31:0]          dq_mag;
    logic                 cur_pos, cur_neg, cur_zero;
    logic                 cap_nz;
    logic signed [LW-1:0] t_w, s_w;
    logic [22:0]          lim;
    logic [24:0]          cur_abs;
    assign dq_mag   = r_dq[31] ? 32'(-r_dq) : 32'(r_dq);
    assign cur_zero = (r_cur == 0);
    assign cur_neg  = r_cur[23];
    assign cur_pos  = !cur_neg && !cur_zero;
    assign cap_nz   = (r_cap != 0);
    assign t_w      = $signed({{(LW-LV){1'b0}}, r_t});
    assign s_w      = $signed({{(LW-LV){1'b0}}, r_s});
    assign lim      = 23'(r_nom) * 23'd100;
    assign cur_abs  = cur_neg ? 25'(-$signed({r_cur[23], r_cur})) : 25'({1'b0, r_cur});

    logic need_tdiv;
    assign need_tdiv = cap_nz && (((r_st == bsds_pkg::BST_CHG) && (r_frac < 17'd65536))
                               || ((r_st == bsds_pkg::BST_DIS) && (r_frac != 0)));

    // branch choice for the shown level
    logic [LV-1:0]  dlt;
    logic           ends, cond, low, high;
    logic [LV-1:0]  raw_num, raw_den, rnum, rden;
    logic           rok;
    bsds_pkg::t_br  br;
    assign dlt  = (r_t > r_s) ? (r_t - r_s) : (r_s - r_t);
    assign ends = (r_t == 0) || (r_t == bsds_pkg::FULL_LVL);
    assign cond = (cur_pos && r_st == bsds_pkg::BST_CHG)
               || (cur_neg && r_st == bsds_pkg::BST_DIS) || (cur_zero && ends);
    assign low  = ((r_t <= bsds_pkg::PCT3 && r_s >= bsds_pkg::PCT6)
                || (r_t <= bsds_pkg::PCT8 && r_s >= bsds_pkg::PCT10))
                && cur_neg && (cur_abs < {2'b0, lim});
    assign high = ((r_t >= bsds_pkg::PCT97 && r_s <= bsds_pkg::PCT95)
                || (r_t >= bsds_pkg::PCT92 && r_s <= bsds_pkg::PCT90))
                && cur_pos && (cur_abs < {2'b0, lim});

    always_comb begin
        raw_num = cur_neg ? r_s : (bsds_pkg::FULL_LVL - r_s);
        raw_den = cur_neg ? r_t : (bsds_pkg::FULL_LVL - r_t);
        rnum    = raw_num;
        rden    = raw_den;
        if ((27'(raw_num) * 27'd10) < (27'(raw_den) * 27'd6)) begin
            rnum = 23'd6;
            rden = 23'd10;
        end else if (27'(raw_num) > (27'(raw_den) * 27'd10)) begin
            rnum = 23'd10;
            rden = 23'd1;
        end
        rok = cap_nz && (rden != 0);
    end

    always_comb begin
        if (dlt > bsds_pkg::HALF_PCT) begin
            if (!cond)            br = bsds_pkg::BR_HOLD;
            else if (ends)        br = bsds_pkg::BR_END;
            else if (low || high) br = bsds_pkg::BR_BLEND;
            else if (!cur_zero)   br = bsds_pkg::BR_RATIO;
            else                  br = bsds_pkg::BR_HOLD;
        end else begin
            if ((r_s < r_t && cur_pos) || (r_s > r_t && cur_neg)) br = bsds_pkg::BR_SNAP;
            else if (!cur_zero && cap_nz)                         br = bsds_pkg::BR_STEP;
            else                                                  br = bsds_pkg::BR_KEEP;
        end
    end

    logic [3:0] bw;
    assign bw = (dlt >= bsds_pkg::PCT10) ? 4'd6 : ((dlt >= bsds_pkg::PCT5) ? 4'd9 : 4'd15);

    // level updates
    logic signed [LW-1:0] t_new, s_new;
    always_comb begin
        t_new = t_w;
        case (r_st)
            bsds_pkg::BST_CHG: begin
                if (r_frac < 17'd65536) t_new = t_w + (cap_nz ? qs : '0);
                else                    t_new = $signed({{(LW-LV){1'b0}}, bsds_pkg::FULL_LVL});
            end
            bsds_pkg::BST_DIS: begin
                if (r_frac != 0) t_new = t_w + (cap_nz ? qs : '0);
                else             t_new = '0;
            end
            default: t_new = t_w;
        endcase
    end

    always_comb begin
        s_new = s_w;
        case (r_br)
            bsds_pkg::BR_END:   s_new = qs;
            bsds_pkg::BR_BLEND: s_new = s_w + qs;
            bsds_pkg::BR_STEP:  s_new = s_w + qs;
            bsds_pkg::BR_SNAP:  s_new = t_w;
            bsds_pkg::BR_RATIO: begin
                s_new = s_w + (rok ? qs : '0);
                if (cur_neg && s_new <= 0) begin
                    s_new = $signed({{(LW-LV){1'b0}}, bsds_pkg::PCT1});
                end
                if (cur_pos && s_new >= $signed({{(LW-LV){1'b0}}, bsds_pkg::FULL_LVL})) begin
                    s_new = $signed({{(LW-LV){1'b0}}, bsds_pkg::FULL_LVL});
                end
            end
            default: s_new = s_w;
        endcase
        // small gap: target at either end pins the shown level
        if ((r_br == bsds_pkg::BR_SNAP || r_br == bsds_pkg::BR_STEP
             || r_br == bsds_pkg::BR_KEEP) && ends) begin
            s_new = t_w;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nom <= '0;
            r_cr  <= '0;
            r_dr  <= '0;
            r_t   <= '0;
            r_s   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_nom <= i_cfg_nominal_capacity;
            end
            if (i_cmd.op == bsds_pkg::OP_LOAD) begin
                r_cr <= n_cr;
                r_dr <= n_dr;
            end
            if (i_cmd.op == bsds_pkg::OP_TUPD) begin
                r_t <= bsds_pkg::clamp_lvl(t_new);
            end
            if (i_cmd.op == bsds_pkg::OP_SUPD) begin
                r_s <= bsds_pkg::clamp_lvl(s_new);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bsds_pkg::OP_LOAD: begin
                r_cur  <= i_current_ma;
                r_frac <= i_coulomb_fraction;
                r_dq   <= i_delta_charge;
                r_cap  <= i_usable_capacity;
                r_st   <= n_st;
            end
            bsds_pkg::OP_TMUL: begin
                r_nmag <= NW'(dq_mag)
                          * NW'((r_st == bsds_pkg::BST_CHG) ? 7'd120 : 7'd105);
                r_den  <= DW'(r_cap);
                r_neg  <= r_dq[31];
            end
            bsds_pkg::OP_SEL: begin
                r_br   <= br;
                r_rnum <= rnum;
                r_rden <= rden;
                case (br)
                    bsds_pkg::BR_END: begin
                        r_nmag <= (NW'(r_t) * NW'(3)) + (NW'(r_s) * NW'(7));
                        r_den  <= DW'(10);
                        r_neg  <= 1'b0;
                    end
                    bsds_pkg::BR_BLEND: begin
                        r_nmag <= NW'(dlt) * NW'(bw);
                        r_den  <= DW'(10000);
                        r_neg  <= (r_t < r_s);
                    end
                    default: begin
                        r_nmag <= NW'(dq_mag) * NW'(60);
                        r_den  <= DW'(r_cap);
                        r_neg  <= r_dq[31];
                    end
                endcase
            end
            bsds_pkg::OP_RM0: begin
                r_pmag <= 39'(dq_mag) * (cur_neg ? 39'd110 : 39'd120);
                r_neg  <= r_dq[31];
            end
            bsds_pkg::OP_RM1: begin
                r_nmag <= NW'(r_pmag[19:0]) * NW'(r_rnum);
            end
            bsds_pkg::OP_RM2: begin
                r_nmag <= r_nmag + ((NW'(r_pmag[38:20]) * NW'(r_rnum)) << 20);
            end
            bsds_pkg::OP_RM3: begin
                r_den <= DW'(r_cap) * DW'(r_rden);
            end
            bsds_pkg::OP_PUB: begin
                r_o_s  <= r_s;
                r_o_t  <= r_t;
                r_o_st <= r_st;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.div_busy  = div_busy;
    assign o_stat.need_tdiv = need_tdiv;
    assign o_stat.br        = br;
    assign o_stat.ratio_ok  = rok;

    assign o_shown_percent  = r_o_s;
    assign o_target_percent = r_o_t;
    assign o_battery_status = r_o_st;
endmodule

FILE: bench/bsds_checker.sv
// ----------------------------------------------------------------------------
// bsds_checker
// watches the config, input and result channels of the soc display smoother,
// predicts every result from its own copy of the block state and compares
// ----------------------------------------------------------------------------
module bsds_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [15:0]        i_cfg_nominal_capacity,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [23:0] i_current_ma,
    input  logic [16:0]        i_coulomb_fraction,
    input  logic signed [31:0] i_delta_charge,
    input  logic [25:0]        i_usable_capacity,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [22:0]        i_shown_percent,
    input  logic [22:0]        i_target_percent,
    input  logic [1:0]         i_battery_status,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FULL = 64'sd6553600;
    localparam longint PCT  = 64'sd65536;

    typedef struct packed {
        logic [22:0] shown;
        logic [22:0] target;
        logic [1:0]  status;
    } t_soc_result;

    t_soc_result soc_expected_q[$];
    longint      nominal_ah;
    int          chg_run, dis_run;
    longint      target_lvl, shown_lvl;

    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clip_level(longint v);
        if (v > FULL) return FULL;
        if (v < 0) return 0;
        return v;
    endfunction

    function automatic t_soc_result smooth_tick(longint cur, longint frac, longint dq,
                                                longint cap);
        longint      lim, t, s, d, w, num, den, g;
        logic [1:0]  st;
        bit          ends, low, high;
        t_soc_result r;
        lim = nominal_ah * 100;
        t   = target_lvl;
        s   = shown_lvl;
        st  = bsds_pkg::BST_IDLE;
        // three-sample debounce of the current sign
        if (cur == 0) begin
            chg_run = 0;
            dis_run = 0;
        end else if (cur > 0) begin
            dis_run = 0;
            chg_run++;
            if (chg_run >= 3) begin
                chg_run = 4;
                st = bsds_pkg::BST_CHG;
            end
        end else begin
            chg_run = 0;
            dis_run++;
            if (dis_run >= 3) begin
                dis_run = 4;
                st = bsds_pkg::BST_DIS;
            end
        end
        if (st == bsds_pkg::BST_CHG) begin
            if (frac < 65536) t += cap != 0 ? round_div(dq * 120, cap) : 0;
            else t = FULL;
        end else if (st == bsds_pkg::BST_DIS) begin
            if (frac > 0) t += cap != 0 ? round_div(dq * 105, cap) : 0;
            else t = 0;
        end
        t = clip_level(t);
        d = t > s ? t - s : s - t;
        if (d > 32768) begin
            ends = (t == 0 || t == FULL);
            if ((cur > 0 && st == bsds_pkg::BST_CHG) || (cur < 0 && st == bsds_pkg::BST_DIS) ||
                (cur == 0 && ends)) begin
                low  = ((t <= 3*PCT && s >= 6*PCT) || (t <= 8*PCT && s >= 10*PCT))
                       && cur < 0 && -cur < lim;
                high = ((t >= 97*PCT && s <= 95*PCT) || (t >= 92*PCT && s <= 90*PCT))
                       && cur > 0 && cur < lim;
                if (ends) begin
                    s = round_div(3 * t + 7 * s, 10);
                end else if (low || high) begin
                    w = d >= 10*PCT ? 6 : (d >= 5*PCT ? 9 : 15);
                    s += round_div((t - s) * w, 10000);
                end else if (cur != 0) begin
                    if (cur < 0) begin
                        num = s; den = t; g = 110;
                    end else begin
                        num = FULL - s; den = FULL - t; g = 120;
                    end
                    // ratio weight clamped to 0.6 .. 10
                    if (num * 10 < den * 6) begin
                        num = 6; den = 10;
                    end else if (num > den * 10) begin
                        num = 10; den = 1;
                    end
                    if (cap != 0 && den > 0) s += round_div(dq * g * num, cap * den);
                    if (cur < 0 && s <= 0) s = PCT;
                    if (cur > 0 && s >= FULL) s = FULL;
                end
            end
        end else begin
            if ((s < t && cur > 0) || (s > t && cur < 0)) s = t;
            else if (cur != 0) s += cap != 0 ? round_div(dq * 60, cap) : 0;
            if (t == 0 || t == FULL) s = t;
        end
        s = clip_level(s);
        target_lvl = t;
        shown_lvl  = s;
        r.shown  = s[22:0];
        r.target = t[22:0];
        r.status = st;
        return r;
    endfunction

    assign o_pending = soc_expected_q.size();

    always @(posedge i_clk) begin
        t_soc_result exp_r;
        if (!i_rst_n) begin
            nominal_ah = 0;
            chg_run    = 0;
            dis_run    = 0;
            target_lvl = 0;
            shown_lvl  = 0;
            soc_expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) nominal_ah = i_cfg_nominal_capacity;
            if (i_in_valid && i_in_ready)
                soc_expected_q.push_back(smooth_tick(i_current_ma, i_coulomb_fraction,
                                                     i_delta_charge, i_usable_capacity));
            if (i_out_valid && i_out_ready) begin
                if (soc_expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result beat");
                end else begin
                    exp_r = soc_expected_q.pop_front();
                    if (exp_r.shown !== i_shown_percent || exp_r.target !== i_target_percent
                        || exp_r.status !== i_battery_status) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch shown %0d/%0d target %0d/%0d status %0d/%0d",
                                     exp_r.shown, i_shown_percent, exp_r.target,
                                     i_target_percent, exp_r.status, i_battery_status);
                    end
                end
            end
        end
    end

    initial o_fail_count = 0;

endmodule

FILE: bench/tb_battery_soc_display_smoother_unit.sv
// ----------------------------------------------------------------------------
// tb_battery_soc_display_smoother_unit
// drives directed and random gauge ticks through several nominal capacity
// settings with random gaps and stalls; a checker module judges each result
// ----------------------------------------------------------------------------
module tb_battery_soc_display_smoother_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_nominal_capacity = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [23:0] i_current_ma = '0;
    logic [16:0]        i_coulomb_fraction = '0;
    logic signed [31:0] i_delta_charge = '0;
    logic [25:0]        i_usable_capacity = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [22:0]        o_shown_percent;
    logic [22:0]        o_target_percent;
    logic [1:0]         o_battery_status;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit calm = 1'b0;        // phase with no idling on either side
    int nominal_now = 0;

    always #4 i_clk = ~i_clk;

    battery_soc_display_smoother_unit dut (.*);

    bsds_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_nominal_capacity(i_cfg_nominal_capacity),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_current_ma(i_current_ma), .i_coulomb_fraction(i_coulomb_fraction),
        .i_delta_charge(i_delta_charge), .i_usable_capacity(i_usable_capacity),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_shown_percent(o_shown_percent), .i_target_percent(o_target_percent),
        .i_battery_status(o_battery_status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // sink side: random stall after every result beat, none in a calm phase
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall = 0;
        end else if (stall > 0) begin
            stall--;
            if (stall == 0) i_out_ready <= 1'b1;
        end else if (o_out_valid && i_out_ready) begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // one input beat; valid is only dropped ahead of a gap, never between beats
    task automatic send_tick(logic signed [23:0] cur, logic [16:0] frac,
                             logic signed [31:0] dq, logic [25:0] cap);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_current_ma       <= cur;
        i_coulomb_fraction <= frac;
        i_delta_charge     <= dq;
        i_usable_capacity  <= cap;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // capacity writes only once the block has drained
    task automatic write_nominal(logic [15:0] ah);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid            <= 1'b1;
        i_cfg_nominal_capacity <= ah;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        nominal_now = ah;
    endtask

    // mostly sign-consistent runs with plausible charge steps, some raw noise
    task automatic random_ticks(int count);
        int   run, sgn, mag_hi;
        logic [25:0] cap;
        logic [16:0] frac;
        longint cur, dq;
        while (count > 0) begin
            run = $urandom_range(1, 20);
            sgn = $urandom_range(0, 4);     // 0 idle, 1..2 charge, 3..4 discharge
            cap = 26'($urandom_range(500, 5000));
            for (int k = 0; k < run && count > 0; k++) begin
                if ($urandom_range(0, 99) < 12) begin
                    send_tick(24'($urandom), 17'($urandom), 32'($urandom), 26'($urandom));
                end else begin
                    mag_hi = (nominal_now * 100 > 2) ? nominal_now * 100 : 2;
                    cur = $urandom_range(0, 1) ? $urandom_range(1, mag_hi - 1)
                                               : $urandom_range(1, 8388607);
                    dq  = $urandom_range(0, 3000000);
                    if (sgn == 0) cur = 0;
                    else if (sgn >= 3) begin
                        cur = -cur;
                        dq  = -dq;
                    end
                    case ($urandom_range(0, 9))
                        0: frac = 17'd0;
                        1: frac = 17'd65536;
                        2: frac = 17'($urandom);
                        default: frac = 17'($urandom_range(1, 65535));
                    endcase
                    send_tick(24'(cur), frac, 32'(dq), cap);
                end
                count--;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, debounce, full and empty pulls, zero capacity
        write_nominal(16'd100);
        calm = 1'b1;
        send_tick(24'sd0, 17'd0, 32'sd0, 26'd0);
        repeat (3) send_tick(24'sd5000, 17'd30000, 32'sd1310720, 26'd2000);
        send_tick(24'sd50, 17'd65536, 32'sd1310720, 26'd2000);
        send_tick(24'sd50, 17'h1ffff, 32'sd1310720, 26'd2000);
        send_tick(24'sd8388607, 17'd1000, 32'sh7fffffff, 26'd0);
        calm = 1'b0;
        repeat (3) send_tick(-24'sd8388608, 17'd0, -32'sh80000000, 26'h3ffffff);
        send_tick(-24'sd50, 17'd1, -32'sd1310720, 26'd1);
        send_tick(24'sd0, 17'd20000, 32'sd0, 26'd2000);
        repeat (4) send_tick(-24'sd30, 17'd40000, -32'sd655360, 26'd1500);
        repeat (4) send_tick(24'sd30, 17'd40000, 32'sd655360, 26'd1500);
        send_tick(24'sd1, 17'd65535, -32'sd1, 26'd1);

        // random phases across capacity settings, extremes included
        random_ticks(80);
        write_nominal(16'd65535);
        random_ticks(80);
        write_nominal(16'd0);
        calm = 1'b1;
        random_ticks(80);
        calm = 1'b0;
        write_nominal(16'($urandom));
        random_ticks(80);
        write_nominal(16'd1);
        random_ticks(80);

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
